FILE: src/msc_pkg.sv
package msc_pkg;

  localparam logic [3:0] ST_OK             = 4'd0;
  localparam logic [3:0] ST_NOT_READY      = 4'd1;
  localparam logic [3:0] ST_HALTED         = 4'd2;
  localparam logic [3:0] ST_FETCH_ALIGN    = 4'd3;
  localparam logic [3:0] ST_BELOW_BASE     = 4'd4;
  localparam logic [3:0] ST_PAST_ROM       = 4'd5;
  localparam logic [3:0] ST_BAD_FUNCT      = 4'd6;
  localparam logic [3:0] ST_BAD_OPCODE     = 4'd7;
  localparam logic [3:0] ST_LOAD_ALIGN     = 4'd8;
  localparam logic [3:0] ST_LOAD_UNMAPPED  = 4'd9;
  localparam logic [3:0] ST_STORE_ALIGN    = 4'd10;
  localparam logic [3:0] ST_STORE_UNMAPPED = 4'd11;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;

  localparam logic [31:0] ROM_BASE     = 32'hBFC0_0000;
  localparam logic [31:0] SCR_BASE     = 32'h7000_0000;
  localparam logic [31:0] IO_BASE      = 32'h1C00_0000;
  localparam logic [31:0] JUMP_HI_MASK = 32'hF000_0000;
  localparam logic [31:0] JUMP_IDX_MASK = 32'h03FF_FFFF;

  localparam logic [1:0] SEL_MAIN    = 2'd0;
  localparam logic [1:0] SEL_SCRATCH = 2'd1;
  localparam logic [1:0] SEL_IO      = 2'd2;

  typedef struct packed {
    logic [3:0]  status;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        load;
    logic        store;
    logic [1:0]  sel;
    logic [31:0] npc;
    logic [31:0] addr;
  } exec_t;

endpackage

FILE: src/msc_ifs.sv
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [3:0]  status;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [63:0] cycle_count;
  modport source (output valid, output next_pc, output status, output reg_written,
                  output reg_index, output reg_value, output cycle_count, input ready);
  modport sink (input valid, input next_pc, input status, input reg_written,
                input reg_index, input reg_value, input cycle_count, output ready);
endinterface

FILE: src/msc_ram.sv
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/msc_alu.sv
module msc_alu import msc_pkg::*; #(
  parameter int MAIN_RAM_WORDS = 4096,
  parameter int SCRATCH_WORDS = 4096,
  parameter int IO_RAM_WORDS = 4096
) (
  input  logic [31:0] pc,
  input  logic [22:0] rom_size,
  input  logic        halted,
  input  logic [31:0] ins,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output exec_t       x
);
  localparam logic [32:0] MainBytes = 33'(MAIN_RAM_WORDS) << 2;
  localparam logic [32:0] ScrBytes  = 33'(SCRATCH_WORDS) << 2;
  localparam logic [32:0] IoBytes   = 33'(IO_RAM_WORDS) << 2;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] simm, seq, addr, off_s, off_i, rom_off;
  logic        in_main, in_scr, in_io, mapped;

  always_comb begin
    op   = ins[31:26];
    rt   = ins[20:16];
    rd   = ins[15:11];
    sh   = ins[10:6];
    fn   = ins[5:0];
    simm = {{16{ins[15]}}, ins[15:0]};
    seq  = pc + 32'd4;
    addr = a + simm;
    off_s = addr - SCR_BASE;
    off_i = addr - IO_BASE;
    rom_off = pc - ROM_BASE;
    in_main = {1'b0, addr} < MainBytes;
    in_scr  = (addr >= SCR_BASE) && ({1'b0, off_s} < ScrBytes);
    in_io   = (addr >= IO_BASE) && ({1'b0, off_i} < IoBytes);
    mapped  = in_main || in_scr || in_io;

    x = '0;
    x.npc = seq;
    x.status = ST_OK;
    if (in_main) begin
      x.sel = SEL_MAIN;
      x.addr = addr;
    end else if (in_scr) begin
      x.sel = SEL_SCRATCH;
      x.addr = off_s;
    end else begin
      x.sel = SEL_IO;
      x.addr = off_i;
    end

    if (rom_size == '0) begin
      x.status = ST_NOT_READY;
    end else if (halted) begin
      x.status = ST_HALTED;
    end else if (pc[1:0] != 2'b00) begin
      x.status = ST_FETCH_ALIGN;
    end else if (pc < ROM_BASE) begin
      x.status = ST_BELOW_BASE;
    end else if (({1'b0, rom_off} + 33'd4) > {10'd0, rom_size}) begin
      x.status = ST_PAST_ROM;
    end else begin
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL: begin x.wr = 1'b1; x.idx = rd; x.val = b << sh; end
            FN_ADD: begin x.wr = 1'b1; x.idx = rd; x.val = a + b; end
            FN_SUB: begin x.wr = 1'b1; x.idx = rd; x.val = a - b; end
            FN_JR:  x.npc = a;
            default: x.status = ST_BAD_FUNCT;
          endcase
        end
        OP_LUI:  begin x.wr = 1'b1; x.idx = rt; x.val = {ins[15:0], 16'd0}; end
        OP_ADDI: begin x.wr = 1'b1; x.idx = rt; x.val = addr; end
        OP_BEQ: begin
          if (a == b) begin
            x.npc = seq + {simm[29:0], 2'b00};
          end
        end
        OP_LW: begin
          if (addr[1:0] != 2'b00) begin
            x.status = ST_LOAD_ALIGN;
          end else if (!mapped) begin
            x.status = ST_LOAD_UNMAPPED;
          end else begin
            x.wr = 1'b1; x.idx = rt; x.load = 1'b1;
          end
        end
        OP_SW: begin
          if (addr[1:0] != 2'b00) begin
            x.status = ST_STORE_ALIGN;
          end else if (!mapped) begin
            x.status = ST_STORE_UNMAPPED;
          end else begin
            x.store = 1'b1;
          end
        end
        OP_J: x.npc = (seq & JUMP_HI_MASK) | ((ins & JUMP_IDX_MASK) << 2);
        default: x.status = ST_BAD_OPCODE;
      endcase
    end

    if (x.status != ST_OK || x.idx == 5'd0) begin
      x.wr = 1'b0;
      x.load = 1'b0;
    end
    if (x.status != ST_OK) begin
      x.store = 1'b0;
    end
  end
endmodule

FILE: src/mips_subset_core_step.sv
// Each item passes through execute, then writeback, before its result is valid.
// A new item is not taken while one is in flight; the next item is taken as the writeback
// of the previous one commits, since it needs the new PC and registers.
// Reset: synchronous; afterwards a clearing pass over the largest of MAIN_RAM_WORDS, SCRATCH_WORDS
// and IO_RAM_WORDS zeroes the data RAMs, no items are taken during it.
module mips_subset_core_step import msc_pkg::*; #(
  parameter int MAIN_RAM_WORDS = 4096,
  parameter int SCRATCH_WORDS = 4096,
  parameter int IO_RAM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [22:0] cfg_data,
  msc_in_if.sink      in_ch,
  msc_out_if.source   out_ch
);
  localparam int MAW = (MAIN_RAM_WORDS > 1) ? $clog2(MAIN_RAM_WORDS) : 1;
  localparam int SAW = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;
  localparam int IAW = (IO_RAM_WORDS > 1) ? $clog2(IO_RAM_WORDS) : 1;
  localparam int ClrMax0 = (MAIN_RAM_WORDS > SCRATCH_WORDS) ? MAIN_RAM_WORDS : SCRATCH_WORDS;
  localparam int ClrMax = (ClrMax0 > IO_RAM_WORDS) ? ClrMax0 : IO_RAM_WORDS;
  localparam int CW = $clog2(ClrMax + 1);

  // architectural state
  logic [22:0] rom_size;
  logic [31:0] pc;
  logic [63:0] cycle;
  logic        halted;
  logic [31:0] reg_valid;   // cleared register entries read as zero

  // clearing pass
  logic [CW-1:0] clr_cnt;
  logic          clearing;
  assign clearing = clr_cnt != CW'(ClrMax);

  // pipeline control
  logic        e_v, w_v, o_v;
  logic [31:0] ins_e;
  logic        va, vb;
  exec_t       w_x;
  logic        w_done, accept, commit;

  // last register write, forwarded over the read that coincides with it
  logic        fwd_v;
  logic [4:0]  fwd_idx;
  logic [31:0] fwd_val;

  logic [31:0] rf_a, rf_b, a_val, b_val, w_val;
  logic [31:0] main_rd, scr_rd, io_rd;
  exec_t       x;

  assign w_done = !o_v || out_ch.ready;
  assign commit = w_v && w_done;
  assign in_ch.ready = !clearing && !e_v && (!w_v || w_done);
  assign accept = in_ch.valid && in_ch.ready;

  // register file: two copies give the two read ports
  msc_ram #(.WIDTH(32), .DEPTH(32), .AW(5)) u_rf_a (
    .clk(clk), .we(commit && w_x.wr), .waddr(w_x.idx), .wdata(w_val),
    .raddr(in_ch.instruction[25:21]), .rdata(rf_a)
  );
  msc_ram #(.WIDTH(32), .DEPTH(32), .AW(5)) u_rf_b (
    .clk(clk), .we(commit && w_x.wr), .waddr(w_x.idx), .wdata(w_val),
    .raddr(in_ch.instruction[20:16]), .rdata(rf_b)
  );

  always_comb begin
    if (fwd_v && fwd_idx == ins_e[25:21]) begin
      a_val = fwd_val;
    end else begin
      a_val = va ? rf_a : 32'd0;
    end
    if (fwd_v && fwd_idx == ins_e[20:16]) begin
      b_val = fwd_val;
    end else begin
      b_val = vb ? rf_b : 32'd0;
    end
  end

  msc_alu #(
    .MAIN_RAM_WORDS(MAIN_RAM_WORDS), .SCRATCH_WORDS(SCRATCH_WORDS),
    .IO_RAM_WORDS(IO_RAM_WORDS)
  ) u_alu (
    .pc(pc), .rom_size(rom_size), .halted(halted), .ins(ins_e),
    .a(a_val), .b(b_val), .x(x)
  );

  // data RAMs: store at execute, load read issued at execute, data in writeback
  logic st_main, st_scr, st_io;
  assign st_main = e_v && x.store && x.sel == SEL_MAIN;
  assign st_scr  = e_v && x.store && x.sel == SEL_SCRATCH;
  assign st_io   = e_v && x.store && x.sel == SEL_IO;

  // load address stays on the held item while writeback waits for the output
  logic [31:0] ld_addr;
  assign ld_addr = e_v ? x.addr : w_x.addr;

  msc_ram #(.WIDTH(32), .DEPTH(MAIN_RAM_WORDS), .AW(MAW)) u_main (
    .clk(clk),
    .we(clearing ? (32'(clr_cnt) < 32'(MAIN_RAM_WORDS)) : st_main),
    .waddr(clearing ? MAW'(clr_cnt) : x.addr[MAW+1:2]),
    .wdata(clearing ? 32'd0 : b_val),
    .raddr(ld_addr[MAW+1:2]), .rdata(main_rd)
  );
  msc_ram #(.WIDTH(32), .DEPTH(SCRATCH_WORDS), .AW(SAW)) u_scr (
    .clk(clk),
    .we(clearing ? (32'(clr_cnt) < 32'(SCRATCH_WORDS)) : st_scr),
    .waddr(clearing ? SAW'(clr_cnt) : x.addr[SAW+1:2]),
    .wdata(clearing ? 32'd0 : b_val),
    .raddr(ld_addr[SAW+1:2]), .rdata(scr_rd)
  );
  msc_ram #(.WIDTH(32), .DEPTH(IO_RAM_WORDS), .AW(IAW)) u_io (
    .clk(clk),
    .we(clearing ? (32'(clr_cnt) < 32'(IO_RAM_WORDS)) : st_io),
    .waddr(clearing ? IAW'(clr_cnt) : x.addr[IAW+1:2]),
    .wdata(clearing ? 32'd0 : b_val),
    .raddr(ld_addr[IAW+1:2]), .rdata(io_rd)
  );

  always_comb begin
    w_val = w_x.val;
    if (w_x.load) begin
      case (w_x.sel)
        SEL_MAIN:    w_val = main_rd;
        SEL_SCRATCH: w_val = scr_rd;
        default:     w_val = io_rd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size  <= '0;
      pc        <= ROM_BASE;
      cycle     <= '0;
      halted    <= 1'b0;
      reg_valid <= '0;
      clr_cnt   <= '0;
      e_v       <= 1'b0;
      w_v       <= 1'b0;
      o_v       <= 1'b0;
      fwd_v     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rom_size <= cfg_data;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      e_v <= accept;
      w_v <= e_v || (w_v && !w_done);
      if (out_ch.valid && out_ch.ready) begin
        o_v <= 1'b0;
      end
      if (commit) begin
        o_v <= 1'b1;
        if (w_x.status == ST_OK) begin
          pc    <= w_x.npc;
          cycle <= cycle + 64'd4;
          if (w_x.wr) begin
            reg_valid[w_x.idx] <= 1'b1;
            fwd_v <= 1'b1;
          end
        end
        if (w_x.status >= ST_FETCH_ALIGN) begin
          halted <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ins_e <= in_ch.instruction;
    va    <= reg_valid[in_ch.instruction[25:21]];
    vb    <= reg_valid[in_ch.instruction[20:16]];
    if (e_v) begin
      w_x <= x;
    end
    if (commit && w_x.wr) begin
      fwd_idx <= w_x.idx;
      fwd_val <= w_val;
    end
    if (commit) begin
      out_ch.status      <= w_x.status;
      out_ch.reg_written <= w_x.wr;
      out_ch.reg_index   <= w_x.wr ? w_x.idx : 5'd0;
      out_ch.reg_value   <= w_x.wr ? w_val : 32'd0;
      out_ch.next_pc     <= (w_x.status == ST_OK) ? w_x.npc : pc;
      out_ch.cycle_count <= (w_x.status == ST_OK) ? cycle + 64'd4 : cycle;
    end
  end

  assign out_ch.valid = o_v;
endmodule
